// ----- rtl/mdbt_pkg.sv -----
// Shared constants and types for the markup dialect byte translator.
// Used by mdbt_xlate and markup_dialect_byte_translator; depends on nothing.
`default_nettype none
package mdbt_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAX_OUT = 3;
  localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_J     = 8'h4A;
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // code length count, saturating
  localparam logic [1:0] CODE_NONE = 2'd0;
  localparam logic [1:0] CODE_ONE  = 2'd1;
  localparam logic [1:0] CODE_SAT  = 2'd2;

  typedef struct packed {
    logic       in_code;
    logic [1:0] code_count;
    logic       code_starts_j;
  } mdbt_state_t;

  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    logic [MAX_OUT-1:0][BYTE_W-1:0]  bytes;
  } mdbt_xlt_t;

endpackage
`default_nettype wire

// ----- rtl/mdbt_xlate.sv -----
// Combinational translation of one source byte into up to three output bytes.
// Depends on mdbt_pkg for the character codes and the state/result types.
`default_nettype none
module mdbt_xlate (
  input  wire logic [mdbt_pkg::BYTE_W-1:0] src_byte,
  input  wire mdbt_pkg::mdbt_state_t       st,
  output mdbt_pkg::mdbt_state_t            st_nxt,
  output mdbt_pkg::mdbt_xlt_t              res
);
  import mdbt_pkg::*;

  logic pad;
  logic tab;

  assign pad = (st.code_count == CODE_ONE);
  assign tab = st.code_starts_j;

  always_comb begin
    st_nxt    = st;
    res.cnt   = '0;
    res.bytes = '{default: CH_NUL};
    if (src_byte == CH_NUL) begin
      res.cnt      = CNT_W'(1);
      res.bytes[0] = CH_NUL;
      st_nxt       = '0;
    end else if (st.in_code) begin
      if (src_byte == CH_CLOSE) begin
        res.cnt = CNT_W'({1'b0, pad}) + CNT_W'({1'b0, tab});
        if (pad) begin
          res.bytes[0] = CH_SPACE;
          res.bytes[1] = CH_TAB;
        end else begin
          res.bytes[0] = CH_TAB;
        end
        st_nxt = '0;
      end else begin
        if (st.code_count == CODE_NONE) begin
          st_nxt.code_starts_j = (src_byte == CH_J);
        end
        if (st.code_count != CODE_SAT) begin
          st_nxt.code_count = st.code_count + 2'd1;
        end
        res.cnt      = CNT_W'(1);
        res.bytes[0] = src_byte;
      end
    end else begin
      case (src_byte)
        CH_OPEN: begin
          res.cnt      = CNT_W'(1);
          res.bytes[0] = CH_TILDE;
          st_nxt.in_code       = 1'b1;
          st_nxt.code_count    = CODE_NONE;
          st_nxt.code_starts_j = 1'b0;
        end
        CH_LF: begin
          res.cnt      = CNT_W'(3);
          res.bytes[0] = CH_TILDE;
          res.bytes[1] = CH_N;
          res.bytes[2] = CH_SPACE;
        end
        CH_TAB: begin
          res.cnt = '0;
        end
        CH_SPACE: begin
          res.cnt      = CNT_W'(1);
          res.bytes[0] = CH_UNDER;
        end
        default: begin
          res.cnt      = CNT_W'(1);
          res.bytes[0] = src_byte;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/markup_dialect_byte_translator.sv -----
// Markup dialect byte translator: rewrites brace markup into the tilde dialect,
// one source byte per request. An accepted byte sits in an input register; it is
// translated in one pass and its results (zero to three bytes) are loaded into a
// short output queue that drains one byte per cycle unless out_stall is high.
// With one result or none per byte, a steady stream runs at one request per
// cycle while out_stall is low. A newline (three results) or a closing brace
// with pad and tab (two) holds the input while the queue drains. out_last marks
// the final byte produced by each source byte. Depends on mdbt_pkg, mdbt_xlate.
`default_nettype none
module markup_dialect_byte_translator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mdbt_pkg::BYTE_W-1:0] in_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mdbt_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_last
);
  import mdbt_pkg::*;

  logic                           in_v_r, in_v_nxt;
  logic [BYTE_W-1:0]              in_b_r;
  mdbt_state_t                    st_r, st_nxt;
  mdbt_xlt_t                      xlt;
  logic [CNT_W-1:0]               n_r, n_nxt;
  logic [MAX_OUT-1:0][BYTE_W-1:0] q_r, q_nxt;
  logic                           take;
  logic                           load;
  logic                           accept;

  mdbt_xlate u_xlate (
    .src_byte (in_b_r),
    .st       (st_r),
    .st_nxt   (st_nxt),
    .res      (xlt)
  );

  assign out_valid = (n_r != '0);
  assign out_byte  = q_r[0];
  assign out_last  = (n_r == CNT_W'(1));
  assign take      = out_valid && !out_stall;
  // queue is empty now, or its last byte leaves this cycle
  assign load      = in_v_r && ((n_r == '0) || (out_last && take));
  assign in_stall  = in_v_r && !load;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (load) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    n_nxt = n_r;
    q_nxt = q_r;
    if (load) begin
      n_nxt = xlt.cnt;
      q_nxt = xlt.bytes;
    end else if (take) begin
      n_nxt = n_r - CNT_W'(1);
      for (int i = 0; i < MAX_OUT - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      n_r    <= '0;
      st_r   <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      n_r    <= n_nxt;
      if (load) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_b_r <= in_byte;
    end
    q_r <= q_nxt;
  end

  // a zero byte clears the markup state
  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_b_r == CH_NUL) |=> (st_r == '0))
    else $error("state not cleared after message end");

  // outside a code the count and J flag stay clear
  a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.in_code |-> (st_r.code_count == CODE_NONE && !st_r.code_starts_j))
    else $error("stale code state outside markup");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.code_count != 2'd3)
    else $error("code count past saturation");

  // queue never overflows its three entries
  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (n_r <= CNT_W'(MAX_OUT)))
    else $error("output queue overfilled");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for markup_dialect_byte_translator: random stalls on both sides,
// expected output bytes predicted in-line. Depends on mdbt_pkg and the translator RTL.
module testbench;
  import mdbt_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
  } dialect_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  markup_dialect_byte_translator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  always #5 clk = ~clk;

  logic [BYTE_W-1:0] source_q [$];
  dialect_t          dialect_q [$];

  // predictor state
  logic       tr_in_code = 1'b0;
  logic [1:0] tr_count = CODE_NONE;
  logic       tr_starts_j = 1'b0;

  int   n_source = 0;
  int   n_taken = 0;
  int   n_emitted = 0;
  int   n_codes = 0;
  int   n_msgs = 0;
  int   n_fail = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   holds_done = 0;
  bit   in_fire = 1'b0;
  dialect_t want;

  task automatic add_byte(input logic [BYTE_W-1:0] b);
    source_q.push_back(b);
    n_source++;
  endtask

  // expected output bytes for one source byte
  task automatic translate_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] res [0:MAX_OUT-1];
    int n;
    dialect_t d;
    n = 0;
    foreach (res[i]) res[i] = CH_NUL;
    if (c == CH_NUL) begin
      res[n] = CH_NUL;
      n++;
      tr_in_code = 1'b0;
      tr_count = CODE_NONE;
      tr_starts_j = 1'b0;
      n_msgs++;
    end else if (tr_in_code) begin
      if (c == CH_CLOSE) begin
        if (tr_count == CODE_ONE) begin
          res[n] = CH_SPACE;
          n++;
        end
        if (tr_starts_j) begin
          res[n] = CH_TAB;
          n++;
        end
        tr_in_code = 1'b0;
        tr_count = CODE_NONE;
        tr_starts_j = 1'b0;
      end else begin
        if (tr_count == CODE_NONE) tr_starts_j = (c == CH_J);
        if (tr_count != CODE_SAT) tr_count = tr_count + 2'd1;
        res[n] = c;
        n++;
      end
    end else if (c == CH_OPEN) begin
      res[n] = CH_TILDE;
      n++;
      tr_in_code = 1'b1;
      tr_count = CODE_NONE;
      tr_starts_j = 1'b0;
      n_codes++;
    end else if (c == CH_LF) begin
      res[0] = CH_TILDE;
      res[1] = CH_N;
      res[2] = CH_SPACE;
      n = 3;
    end else if (c == CH_SPACE) begin
      res[n] = CH_UNDER;
      n++;
    end else if (c != CH_TAB) begin
      res[n] = c;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      d.b = res[i];
      d.last = (i == n - 1);
      dialect_q.push_back(d);
    end
  endtask

  // mostly no gap, some short, a few long; none at all in calm stretches
  function automatic int next_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // scoreboard: predict on each input request, then check each output request
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      translate_byte(in_byte);
      n_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_emitted++;
      if (dialect_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: unexpected output byte %02h last %0b", $time, out_byte, out_last);
      end else begin
        want = dialect_q.pop_front();
        if (out_byte !== want.b || out_last !== want.last) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: output %0d mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, n_emitted, want.b, want.last, out_byte, out_last);
        end
      end
    end
  end

  // driver: a stalled request keeps its payload
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (source_q.size() > 0) begin
      in_byte <= source_q.pop_front();
      in_valid <= 1'b1;
      gap_left = next_gap((n_taken / 50) % 4 == 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stalls, plus two long hold-offs so the input side backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && n_taken >= 120 + 200 * holds_done) begin
      holds_done++;
      hold_left = 79;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = next_gap((n_emitted / 70) % 4 == 1);
    end
  end

  initial begin
    logic [BYTE_W-1:0] directed [];
    int r;
    int toks;
    int clen;
    logic [BYTE_W-1:0] b;

    directed = '{
      8'h41, 8'hFF, 8'h80, 8'h01, CH_SPACE, CH_TAB, CH_LF, CH_CLOSE,
      CH_OPEN, CH_J, CH_CLOSE,                   // single J: pad and tab
      CH_OPEN, CH_CLOSE,                         // empty code
      CH_OPEN, 8'h41, 8'h42, CH_CLOSE,           // long code, no pad
      CH_OPEN, CH_OPEN, CH_CLOSE,                // brace copied inside a code
      CH_OPEN, CH_J, 8'h78, CH_CLOSE,            // tab only
      CH_OPEN, 8'h51, CH_NUL,                    // zero abandons an open code
      CH_NUL
    };

    foreach (directed[i]) add_byte(directed[i]);

    // random messages: mostly well-formed markup, some noise and broken codes
    while (n_source < 408) begin
      toks = $urandom_range(2, 12);
      for (int t = 0; t < toks; t++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          add_byte(8'($urandom_range(8'h21, 8'h7A)));
        end else if (r < 45) begin
          add_byte(CH_SPACE);
        end else if (r < 52) begin
          add_byte(CH_LF);
        end else if (r < 57) begin
          add_byte(CH_TAB);
        end else if (r < 82) begin
          add_byte(CH_OPEN);
          clen = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(0, 4);
          for (int k = 0; k < clen; k++) begin
            if (k == 0 && $urandom_range(0, 2) == 0) begin
              b = CH_J;
            end else begin
              b = 8'($urandom_range(1, 255));
              if (b == CH_CLOSE) b = 8'h6B;
            end
            add_byte(b);
          end
          if ($urandom_range(0, 9) == 0) add_byte(CH_NUL);
          else add_byte(CH_CLOSE);
        end else if (r < 94) begin
          add_byte(8'($urandom_range(1, 255)));
        end else begin
          add_byte(CH_CLOSE);
        end
      end
      add_byte(CH_NUL);
    end

    r = source_q.size();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (n_taken == r);
    wait (dialect_q.size() == 0);
    repeat (20) @(posedge clk);

    $display("Translated %0d source bytes into %0d output bytes: %0d codes opened, %0d messages.",
             n_taken, n_emitted, n_codes, n_msgs);
    $display("Both sides stalled at random, with %0d long output hold-offs; %0d mismatches.",
             holds_done, n_fail);
    if (n_fail == 0 && dialect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout: %0d source bytes taken, %0d output bytes still expected.",
             n_taken, dialect_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
